// ===== src/rsa_modular_exponentiation_defines.svh =====
// Assertion macros for the RSA modular exponentiation block.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`ifndef ASSERT_OFF
`define RME_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RME_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/rme_pkg.sv =====
// Shared types and constants for the RSA modular exponentiation block.
// No dependencies; imported by rme_mulmod, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package rme_pkg;

    localparam int unsigned CFG_BITS   = 32;
    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned CODE_BITS  = 33;

    // Offset between a letter code and its plaintext value.
    localparam logic [VALUE_BITS-1:0] LETTER_OFFSET = 32'd96;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODULUS      = 2'd0;
    localparam logic [1:0] CFG_PUBLIC_EXP   = 2'd1;
    localparam logic [1:0] CFG_PRIVATE_EXP  = 2'd2;

    localparam logic [CFG_BITS-1:0] RST_MODULUS     = 32'd3233;
    localparam logic [CFG_BITS-1:0] RST_PUBLIC_EXP  = 32'd17;
    localparam logic [CFG_BITS-1:0] RST_PRIVATE_EXP = 32'd2753;

    // Request type carried in the input tuser bit.
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    // Status of the shared modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_status;

endpackage

`default_nettype wire

// ===== src/rme_addmod.sv =====
// Modular adder: (x + y) mod m for x, y below m.
// Leaf arithmetic unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rme_addmod #(
    parameter int unsigned W = 32
) (
    input  wire logic [W-1:0] i_x,
    input  wire logic [W-1:0] i_y,
    input  wire logic [W-1:0] i_m,
    output logic      [W-1:0] o_sum
);

    logic [W:0] w_sum;
    logic [W:0] w_diff;

    assign w_sum  = {1'b0, i_x} + {1'b0, i_y};
    assign w_diff = w_sum - {1'b0, i_m};
    assign o_sum  = (w_sum >= {1'b0, i_m}) ? w_diff[W-1:0] : w_sum[W-1:0];

endmodule

`default_nettype wire

// ===== src/rme_mulmod.sv =====
// Iterative modular multiplier: (a * b) mod m by add-and-double, one modular add per cycle.
// Depends on rme_pkg and rme_addmod.
`timescale 1ns / 1ps
`default_nettype none

module rme_mulmod
    import rme_pkg::*;
#(
    parameter int unsigned W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W-1:0] i_m,
    output t_mul_status       o_status,
    output logic      [W-1:0] o_result
);

    localparam int unsigned CNT_BITS = $clog2(W);

    typedef enum logic [1:0] {
        M_IDLE,
        M_DOUBLE,
        M_ADD
    } t_mstate;

    t_mstate             r_state;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [W-1:0]        r_acc;
    logic [W-1:0]        r_a;
    logic [W-1:0]        r_b;
    logic [W-1:0]        r_m;
    logic [W-1:0]        w_y;
    logic [W-1:0]        w_sum;

    // The one adder either doubles the accumulator or adds the multiplicand.
    assign w_y = (r_state == M_ADD) ? r_a : r_acc;

    rme_addmod #(.W(W)) u_addmod (
        .i_x   (r_acc),
        .i_y   (w_y),
        .i_m   (r_m),
        .o_sum (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_acc   <= '0;
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_m     <= i_m;
                        r_cnt   <= CNT_BITS'(W - 1);
                        r_state <= M_DOUBLE;
                    end
                end
                M_DOUBLE: begin
                    r_acc <= w_sum;
                    if (r_b[W-1]) begin
                        r_state <= M_ADD;
                    end else if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                        r_b   <= {r_b[W-2:0], 1'b0};
                    end
                end
                M_ADD: begin
                    r_acc <= w_sum;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end else begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_b     <= {r_b[W-2:0], 1'b0};
                        r_state <= M_DOUBLE;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_status.busy = (r_state != M_IDLE);
    assign o_status.done = r_done;
    assign o_result      = r_acc;

endmodule

`default_nettype wire

// ===== src/rsa_modular_exponentiation.sv =====
// Channel      | Dir | Fields (lowest bit first)
// s_axis       | in  | tdata: value[31:0]; tuser: req_type[0]
// m_axis       | out | tdata: residue[31:0], text_code[64:32], zero fill; tuser: range_error[0]
// cfg          | in  | wr_en, index (0 modulus, 1 public exp, 2 private exp), data[31:0]
//
// Products come from the single add-and-double multiplier, one modular add per cycle. A range
// error skips the exponentiation and goes straight to the output state. Reset is synchronous
// and active low; it restores the register defaults. A stalled result sits in the output
// register; the next item still runs and then waits in its last state, which keeps the input
// closed until the result drains.
//
// Top level of the RSA modular exponentiation block: square-and-multiply sequencer.
// Depends on rme_pkg, rme_mulmod and rsa_modular_exponentiation_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "rsa_modular_exponentiation_defines.svh"

module rsa_modular_exponentiation
    import rme_pkg::*;
#(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Input stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // value[31:0]
    input  wire logic [0:0]  i_s_axis_tuser,   // req_type[0]
    // Result stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata,   // residue[31:0], text_code[64:32], zeros
    output logic [0:0]       o_m_axis_tuser    // range_error[0]
);

    localparam int unsigned W        = WORD_BITS;
    localparam int unsigned CNT_BITS = $clog2(W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_START,
        S_SQ_WAIT,
        S_MUL_START,
        S_MUL_WAIT,
        S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [CFG_BITS-1:0] r_modulus;
    logic [CFG_BITS-1:0] r_pub_exp;
    logic [CFG_BITS-1:0] r_priv_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= RST_MODULUS;
            r_pub_exp  <= RST_PUBLIC_EXP;
            r_priv_exp <= RST_PRIVATE_EXP;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MODULUS:     r_modulus  <= i_cfg_data;
                CFG_PUBLIC_EXP:  r_pub_exp  <= i_cfg_data;
                CFG_PRIVATE_EXP: r_priv_exp <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Operands are taken in their low WORD_BITS bits, zero-extended where the word is wider.
    logic [63:0]  w_value_x;
    logic [63:0]  w_mod_x;
    logic [63:0]  w_pub_x;
    logic [63:0]  w_priv_x;
    logic [W-1:0] w_value;
    logic [W-1:0] w_mod;
    logic [W-1:0] w_base;
    logic [W-1:0] w_exp;
    logic         w_low_letter;
    logic         w_err;
    logic         w_accept;

    assign w_value_x = {32'd0, i_s_axis_tdata};
    assign w_mod_x   = {32'd0, r_modulus};
    assign w_pub_x   = {32'd0, r_pub_exp};
    assign w_priv_x  = {32'd0, r_priv_exp};
    assign w_value   = w_value_x[W-1:0];
    assign w_mod     = w_mod_x[W-1:0];

    // An encrypt request must carry a letter code above the offset; the base is the code
    // minus the offset. A decrypt request uses the residue itself as the base.
    assign w_low_letter = (i_s_axis_tuser[0] == REQ_ENCRYPT) &&
                          (w_value <= W'(LETTER_OFFSET));
    assign w_base = (i_s_axis_tuser[0] == REQ_ENCRYPT) ? (w_value - W'(LETTER_OFFSET))
                                                       : w_value;
    assign w_exp  = (i_s_axis_tuser[0] == REQ_ENCRYPT) ? w_pub_x[W-1:0] : w_priv_x[W-1:0];
    assign w_err  = w_low_letter || (w_base >= w_mod);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Shared modular multiplier.
    t_mul_status  w_mul_stat;
    logic [W-1:0] w_mul_result;
    logic         r_mul_start;
    logic [W-1:0] r_mul_a;
    logic [W-1:0] r_mul_b;

    rme_mulmod #(.W(W)) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_start),
        .i_a      (r_mul_a),
        .i_b      (r_mul_b),
        .i_m      (w_mod),
        .o_status (w_mul_stat),
        .o_result (w_mul_result)
    );

    // Sequencer working registers.
    logic [W-1:0]        r_base;
    logic [W-1:0]        r_exp;
    logic [W-1:0]        r_res;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_err;
    logic                r_out_valid;
    logic [31:0]         r_out_residue;
    logic [32:0]         r_out_code;
    logic                r_out_err;
    logic [63:0]         w_res_x;
    logic                w_out_load;

    assign w_res_x = {{(64 - W){1'b0}}, r_res};

    // The output register is loaded once it is empty or being drained.
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_base <= w_base;
                        r_exp  <= w_exp;
                        r_cnt  <= CNT_BITS'(W - 1);
                        r_err  <= w_err;
                        // Start from 1 mod m, which is 0 only for a modulus of one.
                        r_res  <= (w_err || (w_mod == W'(1))) ? '0 : W'(1);
                        if (w_err) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SQ_START;
                        end
                    end
                end
                S_SQ_START: begin
                    r_mul_start <= 1'b1;
                    r_mul_a     <= r_res;
                    r_mul_b     <= r_res;
                    r_state     <= S_SQ_WAIT;
                end
                S_SQ_WAIT: begin
                    if (w_mul_stat.done) begin
                        r_res <= w_mul_result;
                        if (r_exp[W-1]) begin
                            r_state <= S_MUL_START;
                        end else if (r_cnt == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_cnt   <= r_cnt - 1'b1;
                            r_exp   <= {r_exp[W-2:0], 1'b0};
                            r_state <= S_SQ_START;
                        end
                    end
                end
                S_MUL_START: begin
                    r_mul_start <= 1'b1;
                    r_mul_a     <= r_res;
                    r_mul_b     <= r_base;
                    r_state     <= S_MUL_WAIT;
                end
                S_MUL_WAIT: begin
                    if (w_mul_stat.done) begin
                        r_res <= w_mul_result;
                        if (r_cnt == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_cnt   <= r_cnt - 1'b1;
                            r_exp   <= {r_exp[W-2:0], 1'b0};
                            r_state <= S_SQ_START;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_residue <= w_res_x[31:0];
                        r_out_code    <= {1'b0, w_res_x[31:0]} + 33'(LETTER_OFFSET);
                        r_out_err     <= r_err;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_code, r_out_residue};
    assign o_m_axis_tuser  = r_out_err;

    // The multiplier is never running while a new transaction can be taken.
    `RME_ASSERT_IMPL(a_idle_mul_quiet, i_clk, i_rst_n, o_s_axis_tready, !w_mul_stat.busy)
    // A finished product only arrives while the sequencer waits for one.
    `RME_ASSERT_IMPL(a_done_in_wait, i_clk, i_rst_n, w_mul_stat.done,
                     (r_state == S_SQ_WAIT) || (r_state == S_MUL_WAIT))
    // A range error always reports a zero residue and the bare offset as text code.
    `RME_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0],
                     (o_m_axis_tdata[31:0] == 32'd0) && (o_m_axis_tdata[64:32] == 33'd96))
    // An accepted transaction closes the input side on the next cycle.
    `RME_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, !o_s_axis_tready)

endmodule

`default_nettype wire

// ===== tb/rsa_modular_exponentiation_tb.sv =====
// Self-checking testbench for rsa_modular_exponentiation: streams encrypt and decrypt requests,
// predicts each residue with its own square-and-multiply model and checks every result in order.
// Depends on rme_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 1ps

module rsa_modular_exponentiation_tb;
    import rme_pkg::*;

    // Longest receiver hold-off; it leaves the block full with its input stalled.
    localparam int unsigned HOLD_CYCLES  = 12000;
    // Covers the longest single item plus the hold-off, which adds to it once.
    localparam int unsigned STALL_LIMIT  = 60000;
    // After the last result, the tail leaves room for a stray result, whether from a range error
    // or from a full computation, so it covers both.
    localparam int unsigned TAIL_CYCLES  = 5000;
    localparam int unsigned PHASE_ITEMS  = 29;
    localparam int unsigned RANDOM_PHASES = 9;
    // Index that maps to no register; writes to it must be ignored.
    localparam logic [1:0]  CFG_UNMAPPED = 2'd3;
    localparam logic [31:0] WORD_MAX     = 32'hFFFF_FFFF;

    typedef struct {
        logic        req_type;
        logic [31:0] value;
    } request_t;

    typedef struct {
        logic [31:0] residue;
        logic [32:0] text_code;
        logic        range_error;
    } result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = CFG_MODULUS;
    logic [31:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // value[31:0]
    logic [0:0]  i_s_axis_tuser = '0;   // req_type[0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [71:0] o_m_axis_tdata;        // residue[31:0], text_code[64:32], zero fill
    logic [0:0]  o_m_axis_tuser;        // range_error[0]

    // Key registers as the block should hold them; only the sequence below writes them.
    logic [31:0] key_modulus = RST_MODULUS;
    logic [31:0] key_public  = RST_PUBLIC_EXP;
    logic [31:0] key_private = RST_PRIVATE_EXP;

    request_t    requests_q[$];      // requests not yet offered to the block
    result_t     residues_due[$];    // predicted results, oldest first
    request_t    offered;            // request currently on the input bus
    result_t     due;
    int unsigned issued_count = 0;   // requests queued by the sequence
    int unsigned taken_count = 0;    // requests the block has accepted
    int unsigned send_idle_pct = 33;
    int unsigned recv_idle_pct = 47;
    int unsigned hold_requests = 0;  // raised by the sequence, served by the receiver
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_count = 0;

    rsa_modular_exponentiation u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected result of one request under the current keys. The modulus never exceeds
    // 32 bits, so every product fits in 64 bits and a plain remainder reduces it exactly.
    function automatic result_t predict_modexp(request_t rq);
        result_t     r;
        logic [63:0] m;
        logic [63:0] base;
        logic [63:0] acc;
        logic [31:0] ex;
        logic        err;
        m    = {32'd0, key_modulus};
        base = '0;
        err  = 1'b0;
        if (rq.req_type == REQ_DECRYPT) begin
            base = {32'd0, rq.value};
            ex   = key_private;
        end else begin
            ex = key_public;
            // A letter code must lie above the offset to give a positive base.
            if (rq.value <= LETTER_OFFSET) begin
                err = 1'b1;
            end else begin
                base = {32'd0, rq.value - LETTER_OFFSET};
            end
        end
        // A base that is not below the modulus is out of range; with a zero
        // modulus this covers every request, so the remainder below never sees zero.
        if (!err && base >= m) begin
            err = 1'b1;
        end
        acc = '0;
        if (!err) begin
            // Starting from one mod m makes a modulus of one give zero, even for a zero exponent.
            acc = 64'd1 % m;
            for (int i = 31; i >= 0; i--) begin
                acc = (acc * acc) % m;
                if (ex[i]) begin
                    acc = (acc * base) % m;
                end
            end
        end
        r.residue     = acc[31:0];
        r.text_code   = {1'b0, acc[31:0]} + {1'b0, LETTER_OFFSET};
        r.range_error = err;
        return r;
    endfunction

    // Input side. A request is predicted at the edge where the block takes it; the keys
    // only change while nothing is in flight, so the prediction sees the right keys.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                residues_due.push_back(predict_modexp(offered));
                taken_count++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = requests_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= offered.value;
                    i_s_axis_tuser  <= offered.req_type;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: every result transaction is checked against the oldest prediction.
    // Backpressure is random, except for the long hold-off, which this process times itself.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (residues_due.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    fail_count++;
                end else begin
                    due = residues_due.pop_front();
                    if (o_m_axis_tdata[31:0] !== due.residue) begin
                        $error("residue: expected %0d, got %0d", due.residue,
                               o_m_axis_tdata[31:0]);
                        fail_count++;
                    end
                    if (o_m_axis_tdata[64:32] !== due.text_code) begin
                        $error("text_code: expected %0d, got %0d", due.text_code,
                               o_m_axis_tdata[64:32]);
                        fail_count++;
                    end
                    if (o_m_axis_tuser[0] !== due.range_error) begin
                        $error("range_error: expected %0b, got %0b", due.range_error,
                               o_m_axis_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left       <= hold_left - 1;
            end else if (hold_requests != holds_served) begin
                holds_served    <= holds_served + 1;
                hold_left       <= HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Ends a hung run: too long without a transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic offer(input logic rq, input logic [31:0] v);
        requests_q.push_back('{rq, v});
        issued_count++;
    endtask

    // Returns once every queued request has been taken and answered.
    task automatic wait_drained();
        while (taken_count != issued_count || residues_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Loads all three keys on back-to-back cycles, optionally followed by a write to
    // the unmapped index. The enable stays high across the burst and drops once.
    task automatic load_keys(input logic [31:0] modulus, input logic [31:0] pub,
                             input logic [31:0] priv, input bit poke_unmapped);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_MODULUS;
        i_cfg_data  <= modulus;
        @(posedge i_clk);
        i_cfg_index <= CFG_PUBLIC_EXP;
        i_cfg_data  <= pub;
        @(posedge i_clk);
        i_cfg_index <= CFG_PRIVATE_EXP;
        i_cfg_data  <= priv;
        if (poke_unmapped) begin
            @(posedge i_clk);
            i_cfg_index <= CFG_UNMAPPED;
            i_cfg_data  <= $urandom();
        end
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        key_modulus = modulus;
        key_public  = pub;
        key_private = priv;
    endtask

    function automatic logic [31:0] pick_exponent();
        case ($urandom_range(4))
            0: return '0;
            1: return WORD_MAX;
            2: return $urandom_range(70, 1);
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed requests whose base lies inside the modulus, so that the
    // full exponentiation runs; the rest are malformed letters and oversized residues.
    task automatic queue_random_requests(input int unsigned n);
        logic [63:0] m;
        logic [63:0] span;
        logic [31:0] v;
        int unsigned pick;
        m = {32'd0, key_modulus};
        for (int unsigned k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                span = m - 1;
                if (span > 64'(WORD_MAX) - 96) begin
                    span = 64'(WORD_MAX) - 96;
                end
                v = 32'(64'd97 + ({32'd0, $urandom()} % span));
                offer(REQ_ENCRYPT, v);
            end else if (pick < 75) begin
                offer(REQ_DECRYPT, 32'({32'd0, $urandom()} % m));
            end else if (pick < 87) begin
                v = $urandom_range(1) ? 32'($urandom_range(96, 0)) : $urandom();
                offer(REQ_ENCRYPT, v);
            end else begin
                v = key_modulus + 32'($urandom_range(3));
                if (v < key_modulus) begin
                    v = WORD_MAX;
                end
                offer(REQ_DECRYPT, $urandom_range(1) ? $urandom() : v);
            end
        end
    endtask

    initial begin
        logic [31:0] modulus;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset keys: letters around the offset, bases below, at and beyond the modulus.
        offer(REQ_ENCRYPT, 32'd97);
        offer(REQ_ENCRYPT, LETTER_OFFSET);
        offer(REQ_ENCRYPT, 32'd0);
        offer(REQ_ENCRYPT, 32'd122);
        offer(REQ_ENCRYPT, LETTER_OFFSET + RST_MODULUS - 1);
        offer(REQ_ENCRYPT, LETTER_OFFSET + RST_MODULUS);
        offer(REQ_ENCRYPT, WORD_MAX);
        offer(REQ_DECRYPT, 32'd0);
        offer(REQ_DECRYPT, 32'd1);
        offer(REQ_DECRYPT, RST_MODULUS - 1);
        offer(REQ_DECRYPT, RST_MODULUS);
        offer(REQ_DECRYPT, WORD_MAX);
        offer(REQ_DECRYPT, 32'd855);
        wait_drained();

        // Zero exponents: zero to the zero gives one.
        load_keys(RST_MODULUS, 32'd0, 32'd0, 1'b1);
        offer(REQ_DECRYPT, 32'd0);
        offer(REQ_ENCRYPT, 32'd122);
        offer(REQ_DECRYPT, RST_MODULUS - 1);
        wait_drained();

        // Modulus of one: only base zero passes and its residue is zero.
        load_keys(32'd1, 32'd5, 32'd0, 1'b0);
        offer(REQ_DECRYPT, 32'd0);
        offer(REQ_DECRYPT, 32'd1);
        offer(REQ_ENCRYPT, 32'd97);
        wait_drained();

        // Modulus of zero: every request is a range error.
        load_keys(32'd0, RST_PUBLIC_EXP, RST_PRIVATE_EXP, 1'b0);
        offer(REQ_DECRYPT, 32'd0);
        offer(REQ_ENCRYPT, 32'd200);
        wait_drained();

        // Widest modulus and public exponent; exponent one on decrypt pushes the text code into its top bit.
        load_keys(WORD_MAX, WORD_MAX, 32'd1, 1'b1);
        offer(REQ_DECRYPT, WORD_MAX - 1);
        offer(REQ_ENCRYPT, WORD_MAX);
        offer(REQ_DECRYPT, 32'd2);
        wait_drained();

        // Random phases: the receiver idles more first, then the sender, then neither.
        // The long hold-off falls in the first phase without random idling.
        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            case (p / 3)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 47;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case ($urandom_range(4))
                0: modulus = 32'($urandom_range(4000, 2));
                1: modulus = 32'($urandom_range(32'h0010_0000, 4001));
                2: modulus = $urandom() | 32'h8000_0000;
                3: modulus = $urandom_range(1) ? 32'd2 : WORD_MAX;
                default: modulus = $urandom() | 32'd2;
            endcase
            load_keys(modulus, pick_exponent(), pick_exponent(), p[0]);
            if (p == 6) begin
                hold_requests++;
            end
            queue_random_requests(PHASE_ITEMS);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rme_pkg.sv
src/rme_addmod.sv
src/rme_mulmod.sv
src/rsa_modular_exponentiation.sv
tb/rsa_modular_exponentiation_tb.sv
